FILE: rtl/jac1d_pkg.sv
// ----------------------------------------------------------------------------
// jac1d_pkg
// Shared types and constants for the 1-D Poisson Jacobi sweep block.
// ----------------------------------------------------------------------------
package jac1d_pkg;

   // default geometry
   localparam int MAX_POINTS_DEF = 1024;
   localparam int VALUE_BITS_DEF = 32;

   // fixed field widths
   localparam int LEN_BITS       = 11;
   localparam int FORCE_BITS     = 32;
   localparam int OP_BITS        = 2;
   localparam int INDEX_BITS     = 10;
   localparam int OUT_BITS       = 32;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   // reset values of the configuration registers
   localparam logic [LEN_BITS-1:0]   ACTIVE_LENGTH_RST = LEN_BITS'(1024);
   localparam logic [FORCE_BITS-1:0] FORCING_TERM_RST  = '0;

   // request operation codes
   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR = 2'd0,
      OP_SWEEP = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ACTIVE_LENGTH = 1'd0,
      CSR_FORCING_TERM  = 1'd1
   } csr_index_type;

   // memory control from the sequencer to the banks
   typedef struct packed {
      logic wr_en;   // write strobe
      logic wr_b;    // write targets bank b
      logic rd_en;   // read strobe
      logic rd_b;    // read data comes from bank b
   } mem_ctl_type;

endpackage

FILE: rtl/jacobi_1d_poisson_sweep.sv
// ----------------------------------------------------------------------------
// jacobi_1d_poisson_sweep
// Double-buffered 1-D Poisson grid with clear, Jacobi sweep and read requests.
// ----------------------------------------------------------------------------
// Usage:
//  - Request: raise start with req_op/req_index; the request is taken on a
//    clock edge where start is high and busy is low.
//  - Response: exactly one per request, shown for one cycle with rsp_valid.
//    rsp_value is the entry for a read, zero otherwise; rsp_out_of_range flags
//    a read at or beyond the active length. The receiver cannot stall it.
//  - Config: csr_wr_en/csr_index/csr_wr_data write active_length (0) or
//    forcing_term (1); write only while busy is low.
//  - Responses come from idle for an out-of-range read or unused op, else
//    from S_READ, S_DRAIN or S_CLEAR. busy drops in the response cycle,
//    so a new request may be taken then.
//  - A sweep streams one entry per cycle through the read port of the current
//    bank while the other bank is written; the clamped active length sets its length.
//  - Reset: bank a is cleared by a pass over all MAX_POINTS entries with busy
//    high; configuration writes are still taken during it.
// ----------------------------------------------------------------------------
module jacobi_1d_poisson_sweep #(
   parameter int MAX_POINTS = jac1d_pkg::MAX_POINTS_DEF,
   parameter int VALUE_BITS = jac1d_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [jac1d_pkg::OP_BITS-1:0]         req_op,
   input  logic [jac1d_pkg::INDEX_BITS-1:0]      req_index,
   output logic                                  rsp_valid,
   output logic [jac1d_pkg::OUT_BITS-1:0]        rsp_value,
   output logic                                  rsp_out_of_range,
   input  logic                                  csr_wr_en,
   input  logic [jac1d_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [jac1d_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int LEN_W  = $clog2(MAX_POINTS + 1);

   logic [jac1d_pkg::LEN_BITS-1:0]   active_length_ff;
   logic [jac1d_pkg::FORCE_BITS-1:0] forcing_term_ff;
   logic [LEN_W-1:0]                 eff_len;
   logic [VALUE_BITS-1:0]            forcing_val;

   jac1d_pkg::mem_ctl_type mem_ctl;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      wr_addr;
   logic [VALUE_BITS-1:0]  wr_data;
   logic [VALUE_BITS-1:0]  rd_data;
   logic [VALUE_BITS-1:0]  a_rd_data;
   logic [VALUE_BITS-1:0]  b_rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_length_ff <= jac1d_pkg::ACTIVE_LENGTH_RST;
         forcing_term_ff  <= jac1d_pkg::FORCING_TERM_RST;
      end else if (csr_wr_en) begin
         unique case (jac1d_pkg::csr_index_type'(csr_index))
            jac1d_pkg::CSR_ACTIVE_LENGTH:
               active_length_ff <= csr_wr_data[jac1d_pkg::LEN_BITS-1:0];
            jac1d_pkg::CSR_FORCING_TERM:
               forcing_term_ff  <= csr_wr_data[jac1d_pkg::FORCE_BITS-1:0];
         endcase
      end
   end

   // length clamped to the grid size; forcing term at grid width
   assign eff_len     = (int'(active_length_ff) > MAX_POINTS) ? LEN_W'(MAX_POINTS)
                                                              : LEN_W'(active_length_ff);
   assign forcing_val = VALUE_BITS'(forcing_term_ff);

   jac1d_seq #(
      .MAX_POINTS (MAX_POINTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .op               (jac1d_pkg::op_type'(req_op)),
      .index            (req_index),
      .eff_len          (eff_len),
      .forcing_term     (forcing_val),
      .mem_ctl          (mem_ctl),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_value        (rsp_value),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // bank a
   jac1d_bank #(
      .DEPTH (MAX_POINTS),
      .WIDTH (VALUE_BITS)
   ) u_bank_a (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en && !mem_ctl.wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (a_rd_data)
   );

   // bank b
   jac1d_bank #(
      .DEPTH (MAX_POINTS),
      .WIDTH (VALUE_BITS)
   ) u_bank_b (
      .clock   (clock),
      .wr_en   (mem_ctl.wr_en && mem_ctl.wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (mem_ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (b_rd_data)
   );

   // current bank does not change between a read and its data
   assign rd_data = mem_ctl.rd_b ? b_rd_data : a_rd_data;

endmodule

FILE: rtl/jac1d_bank.sv
// ----------------------------------------------------------------------------
// jac1d_bank
// One grid buffer: synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module jac1d_bank #(
   parameter int DEPTH = jac1d_pkg::MAX_POINTS_DEF,
   parameter int WIDTH = jac1d_pkg::VALUE_BITS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/jac1d_seq.sv
// ----------------------------------------------------------------------------
// jac1d_seq
// Request sequencer and sweep datapath: clear pass, Jacobi sweep over a
// sliding window of streamed reads, single-entry read, response register.
// ----------------------------------------------------------------------------
module jac1d_seq #(
   parameter int MAX_POINTS = jac1d_pkg::MAX_POINTS_DEF,
   parameter int VALUE_BITS = jac1d_pkg::VALUE_BITS_DEF,
   localparam int ADDR_W = $clog2(MAX_POINTS),
   localparam int LEN_W  = $clog2(MAX_POINTS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  jac1d_pkg::op_type                   op,
   input  logic [jac1d_pkg::INDEX_BITS-1:0]    index,
   input  logic [LEN_W-1:0]                    eff_len,
   input  logic [VALUE_BITS-1:0]               forcing_term,
   output jac1d_pkg::mem_ctl_type              mem_ctl,
   output logic [ADDR_W-1:0]                   rd_addr,
   output logic [ADDR_W-1:0]                   wr_addr,
   output logic [VALUE_BITS-1:0]               wr_data,
   input  logic [VALUE_BITS-1:0]               rd_data,
   output logic                                rsp_valid,
   output logic [jac1d_pkg::OUT_BITS-1:0]      rsp_value,
   output logic                                rsp_out_of_range
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CLEAR = 5'b00010,
      S_SWEEP = 5'b00100,
      S_DRAIN = 5'b01000,
      S_READ  = 5'b10000
   } state_type;

   // saturating add of two fractions
   function automatic logic [VALUE_BITS-1:0] sat_add(
      input logic [VALUE_BITS-1:0] a,
      input logic [VALUE_BITS-1:0] b
   );
      logic [VALUE_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[VALUE_BITS] ? {VALUE_BITS{1'b1}} : s[VALUE_BITS-1:0];
   endfunction

   // control state
   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    cnt_ff, cnt_in;
   logic                cur_b_ff, cur_b_in;
   logic                pend_ff, pend_in;
   logic                arr_v_ff, arr_v_in;
   logic                rsp_valid_ff, rsp_valid_in;
   // payload state
   logic [LEN_W-1:0]                 arr_j_ff, arr_j_in;
   logic                             arr_in_ff, arr_in_in;
   logic [VALUE_BITS-1:0]            mid_ff, mid_in;
   logic [VALUE_BITS-1:0]            fl_ff, fl_in;
   logic [jac1d_pkg::OUT_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic                             rsp_oor_ff, rsp_oor_in;

   logic                  read_oor;
   logic                  issue_rd;
   logic [VALUE_BITS-1:0] arr_data;
   logic [VALUE_BITS-1:0] new_sum;
   logic [LEN_W-1:0]      wr_j;

   assign busy     = (state_ff != S_IDLE);
   assign read_oor = (int'(index) >= int'(eff_len));
   assign issue_rd = (state_ff == S_SWEEP) && (cnt_ff < eff_len);

   // window datapath: arriving entry j completes new value j-1
   assign arr_data = arr_in_ff ? rd_data : '0;
   assign new_sum  = sat_add(fl_ff, arr_data);
   assign wr_j     = arr_j_ff - LEN_W'(1);

   // memory control
   always_comb begin
      mem_ctl.rd_b  = cur_b_ff;
      mem_ctl.rd_en = issue_rd
                      || (state_ff == S_IDLE && start && op == jac1d_pkg::OP_READ
                          && !read_oor);
      if (state_ff == S_CLEAR) begin
         mem_ctl.wr_en = 1'b1;
         mem_ctl.wr_b  = cur_b_ff;
         wr_addr       = cnt_ff[ADDR_W-1:0];
         wr_data       = '0;
      end else begin
         mem_ctl.wr_en = arr_v_ff && (arr_j_ff != '0);
         mem_ctl.wr_b  = !cur_b_ff;
         wr_addr       = wr_j[ADDR_W-1:0];
         wr_data       = {1'b0, new_sum[VALUE_BITS-1:1]};
      end
      rd_addr = (state_ff == S_IDLE) ? ADDR_W'(index) : cnt_ff[ADDR_W-1:0];
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cur_b_in     = cur_b_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = '0;
      rsp_oor_in   = 1'b0;
      arr_v_in     = (state_ff == S_SWEEP);
      arr_j_in     = cnt_ff;
      arr_in_in    = issue_rd;
      mid_in       = mid_ff;
      fl_in        = fl_ff;

      // shift the window on each arriving entry
      if (arr_v_ff) begin
         mid_in = arr_data;
         fl_in  = sat_add(forcing_term, mid_ff);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (op)
                  jac1d_pkg::OP_CLEAR: begin
                     state_in = S_CLEAR;
                     cnt_in   = '0;
                     pend_in  = 1'b1;
                  end
                  jac1d_pkg::OP_SWEEP: begin
                     state_in = S_SWEEP;
                     cnt_in   = '0;
                     mid_in   = '0;
                     fl_in    = forcing_term;
                  end
                  jac1d_pkg::OP_READ: begin
                     if (read_oor) begin
                        rsp_valid_in = 1'b1;
                        rsp_oor_in   = 1'b1;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  jac1d_pkg::OP_NONE: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            cnt_in = cnt_ff + LEN_W'(1);
            if (cnt_ff == LEN_W'(MAX_POINTS - 1)) begin
               state_in     = S_IDLE;
               rsp_valid_in = pend_ff;
               pend_in      = 1'b0;
            end
         end
         S_SWEEP: begin
            if (cnt_ff == eff_len) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + LEN_W'(1);
            end
         end
         S_DRAIN: begin
            // last value written this cycle, then swap banks
            cur_b_in     = !cur_b_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = jac1d_pkg::OUT_BITS'(rd_data);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers; reset starts the clearing pass of bank a
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         cur_b_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         arr_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cur_b_ff     <= cur_b_in;
         pend_ff      <= pend_in;
         arr_v_ff     <= arr_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      arr_j_ff     <= arr_j_in;
      arr_in_ff    <= arr_in_in;
      mid_ff       <= mid_in;
      fl_ff        <= fl_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

FILE: rtl/jac1d_checker.sv
// ----------------------------------------------------------------------------
// jac1d_checker
// Port-level checks for the Jacobi sweep block, bound to the top level.
// ----------------------------------------------------------------------------
module jac1d_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_valid,
   input logic [jac1d_pkg::OUT_BITS-1:0]        rsp_value,
   input logic                                  rsp_out_of_range
);

   // reset starts the clearing pass: busy, and no response
   a_reset_busy: assert property (@(posedge clock) reset |=> busy && !rsp_valid)
      else $error("busy not raised or response shown after reset");

   // an accepted request either keeps the block busy or answers next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted request neither busy nor answered");

   // a response follows an accepted request or a busy period
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("response with no request behind it");

   // out-of-range reads return zero
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_value == '0)
      else $error("out-of-range response carries data");

   // response is reported only from idle-side handoff: busy is low then
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

endmodule

bind jacobi_1d_poisson_sweep jac1d_checker u_jac1d_checker (.*);

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 1-D Poisson Jacobi sweep block. A queue of
// pending requests and register writes feeds a clocked driver; an in-bench
// grid predictor works out each response when its request is taken, and a
// clocked monitor checks every response in order against those predictions.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS        = jac1d_pkg::MAX_POINTS_DEF;
   localparam int REQ_TARGET  = 580;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_WAIT  = 1100;
   localparam int CSR_SETTLE  = 4;

   typedef enum bit { ENTRY_REQUEST, ENTRY_CSR } entry_kind_type;

   typedef struct {
      entry_kind_type                    kind;
      jac1d_pkg::op_type                 op;
      bit [jac1d_pkg::INDEX_BITS-1:0]    index;
      jac1d_pkg::csr_index_type          target;
      bit [jac1d_pkg::CSR_DATA_BITS-1:0] data;
   } bench_entry_type;

   typedef struct {
      bit [jac1d_pkg::OUT_BITS-1:0] value;
      bit                           oor;
   } grid_answer_type;

   // DUT ports; the inputs are known from time zero
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic [jac1d_pkg::OP_BITS-1:0]        req_op = jac1d_pkg::OP_NONE;
   logic [jac1d_pkg::INDEX_BITS-1:0]     req_index = '0;
   logic                                 rsp_valid;
   logic [jac1d_pkg::OUT_BITS-1:0]       rsp_value;
   logic                                 rsp_out_of_range;
   logic                                 csr_wr_en = 1'b0;
   logic [jac1d_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [jac1d_pkg::CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   // bench state
   bench_entry_type pending[$];
   grid_answer_type expected_answers[$];
   int unsigned     mismatches = 0;
   int unsigned     issued = 0;
   int unsigned     quiet_cycles = 0;
   int unsigned     stall_cycles = 0;

   // predictor copy of the grid and the registers
   bit [jac1d_pkg::OUT_BITS-1:0]   grid [2][NPTS];
   bit                             live_bank = 1'b0;
   bit [jac1d_pkg::LEN_BITS-1:0]   len_reg = jac1d_pkg::ACTIVE_LENGTH_RST;
   bit [jac1d_pkg::FORCE_BITS-1:0] force_reg = jac1d_pkg::FORCING_TERM_RST;

   jacobi_1d_poisson_sweep dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_index        (req_index),
      .rsp_valid        (rsp_valid),
      .rsp_value        (rsp_value),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   // clock and one reset pulse
   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // grid predictor
   // ------------------------------------------------------------------------
   function automatic bit [jac1d_pkg::OUT_BITS-1:0] sat_sum(
      bit [jac1d_pkg::OUT_BITS-1:0] a,
      bit [jac1d_pkg::OUT_BITS-1:0] b
   );
      bit [jac1d_pkg::OUT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[jac1d_pkg::OUT_BITS] ? {jac1d_pkg::OUT_BITS{1'b1}}
                                    : s[jac1d_pkg::OUT_BITS-1:0];
   endfunction

   function automatic void grid_apply_csr(jac1d_pkg::csr_index_type target,
                                          bit [jac1d_pkg::CSR_DATA_BITS-1:0] data);
      if (target == jac1d_pkg::CSR_ACTIVE_LENGTH)
         len_reg = data[jac1d_pkg::LEN_BITS-1:0];
      else
         force_reg = data[jac1d_pkg::FORCE_BITS-1:0];
   endfunction

   function automatic grid_answer_type grid_step(jac1d_pkg::op_type op,
                                                 bit [jac1d_pkg::INDEX_BITS-1:0] idx);
      grid_answer_type              ans;
      int                           n;
      bit [jac1d_pkg::OUT_BITS-1:0] left;
      bit [jac1d_pkg::OUT_BITS-1:0] right;
      bit [jac1d_pkg::OUT_BITS-1:0] acc;
      ans.value = '0;
      ans.oor   = 1'b0;
      n = (len_reg > NPTS) ? NPTS : int'(len_reg);
      case (op)
         jac1d_pkg::OP_CLEAR: begin
            for (int i = 0; i < NPTS; i++)
               grid[live_bank][i] = '0;
         end
         jac1d_pkg::OP_SWEEP: begin
            // new value from the old bank; neighbours past either edge are zero
            for (int i = 0; i < n; i++) begin
               left  = (i > 0) ? grid[live_bank][i-1] : '0;
               right = (i + 1 < n) ? grid[live_bank][i+1] : '0;
               acc   = sat_sum(sat_sum(force_reg, left), right);
               grid[!live_bank][i] = acc >> 1;
            end
            live_bank = !live_bank;
         end
         jac1d_pkg::OP_READ: begin
            if (int'(idx) >= n)
               ans.oor = 1'b1;
            else
               ans.value = grid[live_bank][idx];
         end
         default: ;
      endcase
      return ans;
   endfunction

   // ------------------------------------------------------------------------
   // driver: requests and register writes from the pending queue
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive
      bit              go;
      bit              wr;
      bit              calm;
      bench_entry_type head;
      go = start;
      wr = 1'b0;
      if (reset) begin
         go = 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (start && !busy) begin
            expected_answers.push_back(grid_step(jac1d_pkg::op_type'(req_op), req_index));
            go = 1'b0;
         end
         if (!go && pending.size() > 0) begin
            head = pending[0];
            if (head.kind == ENTRY_CSR) begin
               // registers change only once every response is back
               if (expected_answers.size() != 0 || start) begin
                  quiet_cycles <= 0;
               end else if (quiet_cycles < CSR_SETTLE) begin
                  quiet_cycles <= quiet_cycles + 1;
               end else begin
                  void'(pending.pop_front());
                  wr = 1'b1;
                  csr_index   <= head.target;
                  csr_wr_data <= head.data;
                  grid_apply_csr(head.target, head.data);
                  quiet_cycles <= 0;
               end
            end else begin
               calm = (issued >= 250 && issued < 370);
               if (calm || $urandom_range(0, 99) >= 16) begin
                  void'(pending.pop_front());
                  go = 1'b1;
                  req_op    <= head.op;
                  req_index <= head.index;
                  issued    <= issued + 1;
               end
            end
         end
      end
      start     <= go;
      csr_wr_en <= wr;
   end

   // ------------------------------------------------------------------------
   // monitor: one response per request, in order
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch
      grid_answer_type want;
      int unsigned     bad;
      bad = 0;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $error("response with no request outstanding: value %h out_of_range %b",
                   rsp_value, rsp_out_of_range);
            bad++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_value !== want.value) begin
               $error("rsp_value: expected %h, got %h", want.value, rsp_value);
               bad++;
            end
            if (rsp_out_of_range !== want.oor) begin
               $error("rsp_out_of_range: expected %b, got %b", want.oor, rsp_out_of_range);
               bad++;
            end
         end
      end
      if (bad != 0)
         mismatches <= mismatches + bad;
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   int unsigned req_total = 0;
   int          gen_len = NPTS;

   task automatic add_request(jac1d_pkg::op_type op, bit [jac1d_pkg::INDEX_BITS-1:0] index);
      bench_entry_type e;
      e.kind   = ENTRY_REQUEST;
      e.op     = op;
      e.index  = index;
      e.target = jac1d_pkg::CSR_ACTIVE_LENGTH;
      e.data   = '0;
      pending.push_back(e);
      req_total++;
   endtask

   task automatic add_csr(jac1d_pkg::csr_index_type target,
                          bit [jac1d_pkg::CSR_DATA_BITS-1:0] data);
      bench_entry_type e;
      e.kind   = ENTRY_CSR;
      e.op     = jac1d_pkg::OP_NONE;
      e.index  = '0;
      e.target = target;
      e.data   = data;
      pending.push_back(e);
      if (target == jac1d_pkg::CSR_ACTIVE_LENGTH)
         gen_len = (data[jac1d_pkg::LEN_BITS-1:0] > NPTS)
                   ? NPTS : int'(data[jac1d_pkg::LEN_BITS-1:0]);
   endtask

   initial begin : stimulus
      int unsigned                  roll;
      int unsigned                  count;
      bit [jac1d_pkg::LEN_BITS-1:0] len;
      bit [31:0]                    frc;
      bit [31:0]                    upper;

      // full-length sweep first so bank b is written everywhere
      add_request(jac1d_pkg::OP_SWEEP, '0);
      add_request(jac1d_pkg::OP_READ, '0);
      add_request(jac1d_pkg::OP_READ, 10'h3FF);

      // saturating forcing term on a short grid, junk in the upper data bits
      add_csr(jac1d_pkg::CSR_FORCING_TERM, 32'hFFFF_FFFF);
      add_csr(jac1d_pkg::CSR_ACTIVE_LENGTH, 32'hFFFF_F805);
      add_request(jac1d_pkg::OP_SWEEP, '0);
      add_request(jac1d_pkg::OP_SWEEP, 10'h3FF);
      add_request(jac1d_pkg::OP_READ, 10'd0);
      add_request(jac1d_pkg::OP_READ, 10'd2);
      add_request(jac1d_pkg::OP_READ, 10'd4);
      add_request(jac1d_pkg::OP_READ, 10'd5);
      add_request(jac1d_pkg::OP_READ, 10'h3FF);

      // zero length: sweep only swaps banks, every read is out of range
      add_csr(jac1d_pkg::CSR_ACTIVE_LENGTH, 32'd0);
      add_request(jac1d_pkg::OP_SWEEP, '0);
      add_request(jac1d_pkg::OP_READ, 10'd0);
      add_request(jac1d_pkg::OP_READ, 10'h3FF);

      // length past the grid size acts as the full grid
      add_csr(jac1d_pkg::CSR_ACTIVE_LENGTH, 32'h0000_07FF);
      add_csr(jac1d_pkg::CSR_FORCING_TERM, 32'd1);
      add_request(jac1d_pkg::OP_SWEEP, '0);
      add_request(jac1d_pkg::OP_READ, 10'h3FF);
      add_request(jac1d_pkg::OP_READ, 10'd512);

      // clear, a read, then the unused op
      add_request(jac1d_pkg::OP_CLEAR, 10'h155);
      add_request(jac1d_pkg::OP_READ, 10'd3);
      add_request(jac1d_pkg::OP_NONE, 10'h3FF);

      // single point
      add_csr(jac1d_pkg::CSR_ACTIVE_LENGTH, 32'd1);
      add_csr(jac1d_pkg::CSR_FORCING_TERM, 32'h8000_0001);
      add_request(jac1d_pkg::OP_SWEEP, '0);
      add_request(jac1d_pkg::OP_READ, 10'd0);
      add_request(jac1d_pkg::OP_READ, 10'd1);

      // random phases: new settings, then a run of sweeps and reads
      while (req_total < REQ_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            case ($urandom_range(0, 4))
               0: len = 11'd0;
               1: len = 11'd1;
               2: len = 11'd1023;
               3: len = 11'd1024;
               default: len = 11'h7FF;
            endcase
         end else if (roll < 12) begin
            len = 11'($urandom_range(41, 2047));
         end else begin
            len = 11'($urandom_range(1, 40));
         end
         upper = $urandom();
         case ($urandom_range(0, 19))
            0, 1, 2: frc = 32'd0;
            3, 4, 5: frc = 32'hFFFF_FFFF;
            6, 7, 8, 9: frc = $urandom_range(0, 255);
            default: frc = $urandom();
         endcase
         if ($urandom_range(0, 1)) begin
            add_csr(jac1d_pkg::CSR_ACTIVE_LENGTH, {upper[31:jac1d_pkg::LEN_BITS], len});
            add_csr(jac1d_pkg::CSR_FORCING_TERM, frc);
         end else begin
            add_csr(jac1d_pkg::CSR_FORCING_TERM, frc);
            add_csr(jac1d_pkg::CSR_ACTIVE_LENGTH, {upper[31:jac1d_pkg::LEN_BITS], len});
         end

         // long grids are slow to sweep, so keep their runs short
         count = (gen_len > 40) ? $urandom_range(3, 8) : $urandom_range(8, 30);
         for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
               add_request(jac1d_pkg::OP_CLEAR, 10'($urandom()));
            else if (roll < 7)
               add_request(jac1d_pkg::OP_NONE, 10'($urandom()));
            else if (roll < 45)
               add_request(jac1d_pkg::OP_SWEEP, 10'($urandom()));
            else if (roll < 90 && gen_len > 0)
               add_request(jac1d_pkg::OP_READ, 10'($urandom_range(0, gen_len - 1)));
            else
               add_request(jac1d_pkg::OP_READ, 10'($urandom()));
         end
      end

      // drain, then give stray responses time to show up
      while (pending.size() != 0 || start || expected_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
